[design/hde_pkg.sv]
// Shared types, constants and calendar helpers for the HTTP date converter.
package hde_pkg;

    // Character layout of a fixed-format RFC 1123 date.
    localparam logic [5:0] POS_COMMA   = 6'd3;
    localparam logic [5:0] POS_DAY_LO  = 6'd5;
    localparam logic [5:0] POS_DAY_HI  = 6'd6;
    localparam logic [5:0] POS_MON_LO  = 6'd8;
    localparam logic [5:0] POS_MON_HI  = 6'd10;
    localparam logic [5:0] POS_YEAR_LO = 6'd12;
    localparam logic [5:0] POS_YEAR_HI = 6'd15;
    localparam logic [5:0] POS_HOUR_LO = 6'd17;
    localparam logic [5:0] POS_HOUR_HI = 6'd18;
    localparam logic [5:0] POS_MIN_LO  = 6'd20;
    localparam logic [5:0] POS_MIN_HI  = 6'd21;
    localparam logic [5:0] POS_SEC_LO  = 6'd23;
    localparam logic [5:0] POS_SEC_HI  = 6'd24;
    localparam logic [5:0] POS_FINAL   = 6'd28;
    localparam logic [5:0] POS_MAX     = 6'd63;

    // ASCII codes used by the parser.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LY    = 8'h79;
    localparam logic [7:0] CH_LG    = 8'h67;

    // Month indexes, January is zero.
    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd6;
    localparam logic [3:0] MON_AUG = 4'd7;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    // Multiply-add unit widths.
    localparam int MAC_A_W = 32;
    localparam int MAC_B_W = 20;
    localparam int MAC_W   = 52;

    // Year offset that keeps the shifted year positive: 134 eras of 400 years.
    localparam int ERA_BIAS  = 134;
    localparam logic signed [20:0] YEAR_BIAS = 21'sd53600;

    // Reciprocal of 400 scaled by 2^27, exact for offset years below 493447.
    localparam int RECIP_SHIFT = 27;
    localparam logic signed [MAC_B_W-1:0] RECIP_400 = 20'sd335545;

    localparam logic signed [MAC_B_W-1:0] K_NEG_400   = -20'sd400;
    localparam logic signed [MAC_B_W-1:0] K_DAYS_YEAR = 20'sd365;
    localparam logic signed [MAC_B_W-1:0] K_DAYS_ERA  = 20'sd146097;
    localparam logic signed [MAC_B_W-1:0] K_SEC_DAY   = 20'sd86400;
    localparam logic signed [MAC_B_W-1:0] K_SEC_HOUR  = 20'sd3600;
    localparam logic signed [MAC_B_W-1:0] K_SEC_MIN   = 20'sd60;

    // Day number of 0000-03-01 relative to the epoch, plus one for the 1-based day.
    localparam logic signed [MAC_W-1:0] EPOCH_DAY_OFS = 52'sd719469;

    typedef struct packed {
        logic       ok;
        logic [3:0] idx;
    } t_month;

    // Decode the three month letters the way the original parser tests them.
    function automatic t_month month_decode(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        t_month m;
        m.ok  = 1'b1;
        m.idx = MON_JAN;
        case (a)
            CH_J: begin
                if (b == CH_LA) begin
                    m.idx = MON_JAN;
                end else if (b == CH_LU && c == CH_LN) begin
                    m.idx = MON_JUN;
                end else if (b == CH_LU && c == CH_LL) begin
                    m.idx = MON_JUL;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CH_F: m.idx = MON_FEB;
            CH_M: begin
                if (b == CH_LA && c == CH_LR) begin
                    m.idx = MON_MAR;
                end else if (b == CH_LA && c == CH_LY) begin
                    m.idx = MON_MAY;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CH_A: begin
                if (c == CH_LR) begin
                    m.idx = MON_APR;
                end else if (c == CH_LG) begin
                    m.idx = MON_AUG;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CH_S: m.idx = MON_SEP;
            CH_O: m.idx = MON_OCT;
            CH_N: m.idx = MON_NOV;
            CH_D: m.idx = MON_DEC;
            default: m.ok = 1'b0;
        endcase
        return m;
    endfunction

    // Day of a March-based year at which each month starts.
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            MON_JAN: d = 9'd306;
            MON_FEB: d = 9'd337;
            MON_MAR: d = 9'd0;
            MON_APR: d = 9'd31;
            MON_MAY: d = 9'd61;
            MON_JUN: d = 9'd92;
            MON_JUL: d = 9'd122;
            MON_AUG: d = 9'd153;
            MON_SEP: d = 9'd184;
            MON_OCT: d = 9'd214;
            MON_NOV: d = 9'd245;
            MON_DEC: d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[design/hde_mac.sv]
// Shared signed multiply-add unit with a registered result.
module hde_mac
    import hde_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [MAC_A_W-1:0]  i_a,
    input  logic signed [MAC_B_W-1:0]  i_b,
    input  logic signed [MAC_W-1:0]    i_c,
    output logic signed [MAC_W-1:0]    o_r
);

    logic signed [MAC_W-1:0] r_acc;
    logic signed [MAC_W-1:0] n_acc;

    // One product plus one addend per cycle while i_en is high.
    assign n_acc = i_a * i_b + i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_r = r_acc;

endmodule

[design/http_date_to_epoch_seconds.sv]
// Top level: RFC 1123 date characters in, seconds since 1970 out.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------
//   input   | i_valid / o_stall   | i_char_in, i_last
//   output  | o_valid / i_stall   | o_epoch_seconds, o_valid_res
//
// A character is accepted while i_valid is high and o_stall is low. After the
// last character the calendar math makes seven passes through the shared
// multiply-add unit, then the final step loads the output register; a rejected
// date goes straight to the final step. o_stall is high while that sequence
// runs and while the result waits for a free output register. Reset is
// synchronous and active low, and clears the parser state and the output valid.
module http_date_to_epoch_seconds
    import hde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [62:0] o_epoch_seconds,
    output logic        o_valid_res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUOT,
        ST_YOE,
        ST_DOE,
        ST_DAYS,
        ST_SEC,
        ST_HOUR,
        ST_MIN,
        ST_FIN
    } t_state;

    t_state r_state;

    // Parser state.
    logic [5:0]         r_pos;
    logic               r_comma;
    logic [7:0]         r_mon [3];
    logic signed [12:0] r_day;
    logic signed [19:0] r_year;
    logic signed [12:0] r_hour;
    logic signed [12:0] r_min;
    logic signed [12:0] r_sec;

    // Conversion state.
    logic               r_ok;
    logic [3:0]         r_mon_idx;
    logic [18:0]        r_yp;
    logic signed [10:0] r_era;

    // Output register.
    logic               r_out_valid;
    logic [62:0]        r_epoch;
    logic               r_valid_res;

    logic                      accept;
    logic signed [8:0]         dig;
    logic signed [12:0]        n_day;
    logic signed [19:0]        n_year;
    logic signed [12:0]        n_hour;
    logic signed [12:0]        n_min;
    logic signed [12:0]        n_sec;
    t_month                    mon_dec;
    logic                      date_ok;
    logic signed [20:0]        yp_full;
    logic                      out_free;
    logic [9:0]                quot;
    logic [8:0]                yoe;
    logic [1:0]                cent;
    logic                      mac_en;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [MAC_W-1:0]   mac_c;
    logic signed [MAC_W-1:0]   mac_r;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Digit value and the decimal accumulation of each field.
    assign dig    = {1'b0, i_char_in} - 9'sd48;
    assign n_day  = r_day * 13'sd10 + {{4{dig[8]}}, dig};
    assign n_year = r_year * 20'sd10 + {{11{dig[8]}}, dig};
    assign n_hour = r_hour * 13'sd10 + {{4{dig[8]}}, dig};
    assign n_min  = r_min * 13'sd10 + {{4{dig[8]}}, dig};
    assign n_sec  = r_sec * 13'sd10 + {{4{dig[8]}}, dig};

    // Acceptance checks and the year shifted to start in March, made positive.
    assign mon_dec = month_decode(r_mon[0], r_mon[1], r_mon[2]);
    assign date_ok = (r_pos == POS_FINAL) && r_comma && mon_dec.ok;
    assign yp_full = {r_year[19], r_year}
                   - {20'b0, (mon_dec.idx == MON_JAN || mon_dec.idx == MON_FEB)}
                   + YEAR_BIAS;

    // Fields taken from the shared unit's result.
    assign quot = mac_r[RECIP_SHIFT+9:RECIP_SHIFT];
    assign yoe  = mac_r[8:0];
    assign cent = 2'((yoe >= 9'd100) ? 1 : 0) + 2'((yoe >= 9'd200) ? 1 : 0)
                + 2'((yoe >= 9'd300) ? 1 : 0);

    // Operand selection for each step of the conversion.
    always_comb begin
        mac_en = 1'b1;
        mac_a  = '0;
        mac_b  = '0;
        mac_c  = '0;
        unique case (r_state)
            ST_QUOT: begin
                mac_a = {13'b0, r_yp};
                mac_b = RECIP_400;
            end
            ST_YOE: begin
                mac_a = {22'b0, quot};
                mac_b = K_NEG_400;
                mac_c = {33'b0, r_yp};
            end
            ST_DOE: begin
                mac_a = {23'b0, yoe};
                mac_b = K_DAYS_YEAR;
                mac_c = {45'b0, yoe[8:2]} - {50'b0, cent}
                      + {43'b0, month_start(r_mon_idx)};
            end
            ST_DAYS: begin
                mac_a = {{21{r_era[10]}}, r_era};
                mac_b = K_DAYS_ERA;
                mac_c = mac_r + {{39{r_day[12]}}, r_day} - EPOCH_DAY_OFS;
            end
            ST_SEC: begin
                mac_a = mac_r[MAC_A_W-1:0];
                mac_b = K_SEC_DAY;
                mac_c = {{39{r_sec[12]}}, r_sec};
            end
            ST_HOUR: begin
                mac_a = {{19{r_hour[12]}}, r_hour};
                mac_b = K_SEC_HOUR;
                mac_c = mac_r;
            end
            ST_MIN: begin
                mac_a = {{19{r_min[12]}}, r_min};
                mac_b = K_SEC_MIN;
                mac_c = mac_r;
            end
            ST_IDLE, ST_FIN: mac_en = 1'b0;
            default: mac_en = 1'b0;
        endcase
    end

    hde_mac u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_r   (mac_r)
    );

    // Sequencer, parser registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_comma     <= 1'b0;
            r_mon[0]    <= '0;
            r_mon[1]    <= '0;
            r_mon[2]    <= '0;
            r_day       <= '0;
            r_year      <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The final step reloads the output register itself.
            if (r_out_valid && !i_stall && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (r_pos) inside
                            POS_COMMA: r_comma <= (i_char_in == CH_COMMA);
                            [POS_MON_LO:POS_MON_HI]:
                                r_mon[2'(r_pos - POS_MON_LO)] <= i_char_in;
                            [POS_DAY_LO:POS_DAY_HI]:   r_day  <= n_day;
                            [POS_YEAR_LO:POS_YEAR_HI]: r_year <= n_year;
                            [POS_HOUR_LO:POS_HOUR_HI]: r_hour <= n_hour;
                            [POS_MIN_LO:POS_MIN_HI]:   r_min  <= n_min;
                            [POS_SEC_LO:POS_SEC_HI]:   r_sec  <= n_sec;
                            default: ;
                        endcase
                        if (r_pos != POS_MAX) begin
                            r_pos <= r_pos + 6'd1;
                        end
                        if (i_last) begin
                            r_ok      <= date_ok;
                            r_mon_idx <= mon_dec.idx;
                            r_yp      <= yp_full[18:0];
                            r_state   <= date_ok ? ST_QUOT : ST_FIN;
                        end
                    end
                end
                ST_QUOT: r_state <= ST_YOE;
                ST_YOE: begin
                    r_era   <= {1'b0, quot} - 11'(ERA_BIAS);
                    r_state <= ST_DOE;
                end
                ST_DOE:  r_state <= ST_DAYS;
                ST_DAYS: r_state <= ST_SEC;
                ST_SEC:  r_state <= ST_HOUR;
                ST_HOUR: r_state <= ST_MIN;
                ST_MIN:  r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_epoch     <= r_ok ? {{(63-MAC_W){mac_r[MAC_W-1]}}, mac_r} : '0;
                        r_valid_res <= r_ok;
                        r_pos       <= '0;
                        r_comma     <= 1'b0;
                        r_mon[0]    <= '0;
                        r_mon[1]    <= '0;
                        r_mon[2]    <= '0;
                        r_day       <= '0;
                        r_year      <= '0;
                        r_hour      <= '0;
                        r_min       <= '0;
                        r_sec       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_epoch_seconds = r_epoch;
    assign o_valid_res     = r_valid_res;

`ifndef SYNTHESIS
    // A rejected date always reports zero seconds.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_epoch_seconds == '0))
        else $error("rejected date with nonzero seconds");

    // The reciprocal quotient of the shifted year stays within ten bits.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YOE) |-> (mac_r[MAC_W-1:RECIP_SHIFT+10] == '0))
        else $error("year quotient out of range");

    // The year of era is a proper remainder of 400.
    a_yoe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DOE) |-> (mac_r >= 0 && mac_r < 400))
        else $error("year of era out of range");

    // A loaded result always comes from the final sequencer step.
    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid ##1 o_valid) |-> ($past(r_state) == ST_FIN))
        else $error("output loaded outside the final step");
`endif

endmodule
